@@ design/scpa_pkg.sv @@
// Shared types and constants of the size-class pool allocator.
// Holds port widths, parameter defaults, result codes, controller states
// and the command and status structs. Depends on nothing.
`default_nettype none

package scpa_pkg;

  // Port widths fixed by the request and result formats.
  localparam int REQ_W    = 16;
  localparam int BADDR_W  = 19;
  localparam int STATUS_W = 3;
  localparam int CLASS_W  = 3;
  localparam int SLOT_W   = 11;
  localparam int ADDR_W   = 19;
  localparam int BYTES_W  = 11;

  // Defaults for the top-level parameters.
  localparam int NUM_CLASSES_DEF     = 6;
  localparam int REGION_BYTES_DEF    = 65536;
  localparam int MIN_BLOCK_BYTES_DEF = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FREED     = 3'd4,
    ST_EXTERNAL  = 3'd5
  } scpa_status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_FINISH = 2'd2
  } scpa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } scpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop;
  } scpa_stat_t;

endpackage

`default_nettype wire

@@ design/scpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module scpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/scpa_ctrl.sv @@
// Controller of the size-class pool allocator: sequences capture, execute
// and the list-head update of a pop. Depends on scpa_pkg.
`default_nettype none

module scpa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  scpa_pkg::scpa_stat_t  stat,
  output scpa_pkg::scpa_cmd_t   cmd
);
  import scpa_pkg::*;

  scpa_state_t state_r;
  scpa_state_t state_nxt;
  logic        accept;

  // A new request may be taken in the idle state and in the finishing cycle of a pop.
  assign accept = start && (state_r != S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:   state_nxt = stat.pop ? S_FINISH : S_IDLE;
      S_FINISH: state_nxt = accept ? S_EXEC : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = accept;
    cmd.exec    = 1'b0;
    cmd.finish  = 1'b0;
    busy        = 1'b0;
    unique case (state_r)
      S_IDLE:   ;
      S_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      S_FINISH: cmd.finish = 1'b1;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/scpa_dpath.sv @@
// Datapath of the size-class pool allocator: request registers, per-class
// carve counters and list heads, the link RAM and the result registers.
// Depends on scpa_pkg and scpa_ram.
`default_nettype none

module scpa_dpath #(
  parameter int NUM_CLASSES     = scpa_pkg::NUM_CLASSES_DEF,
  parameter int REGION_BYTES    = scpa_pkg::REGION_BYTES_DEF,
  parameter int MIN_BLOCK_BYTES = scpa_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scpa_pkg::scpa_cmd_t           cmd,
  output scpa_pkg::scpa_stat_t          stat,
  input  logic                          in_mode,
  input  logic [scpa_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [scpa_pkg::BADDR_W-1:0]  in_block_address,
  output logic                          out_strobe,
  output logic [scpa_pkg::STATUS_W-1:0] out_status,
  output logic [scpa_pkg::CLASS_W-1:0]  out_block_class,
  output logic [scpa_pkg::SLOT_W-1:0]   out_slot,
  output logic [scpa_pkg::ADDR_W-1:0]   out_address,
  output logic [scpa_pkg::BYTES_W-1:0]  out_block_bytes
);
  import scpa_pkg::*;

  localparam int RG_LOG     = $clog2(REGION_BYTES);
  localparam int MB_LOG     = $clog2(MIN_BLOCK_BYTES);
  localparam int SLOTS0     = REGION_BYTES / MIN_BLOCK_BYTES;
  localparam int CNT_W      = $clog2(SLOTS0 + 1);
  localparam int LINK_DEPTH = 2 * SLOTS0;
  localparam int LIDX_W     = $clog2(LINK_DEPTH);
  localparam int CIDX_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [31:0] POOL_END = 32'(NUM_CLASSES) * 32'(REGION_BYTES);

  // Number of blocks in the region of class c.
  function automatic logic [31:0] slots_of(input logic [CLASS_W-1:0] c);
    return 32'(REGION_BYTES) >> (MB_LOG + 32'(c));
  endfunction

  // First link index of class c: the sum of the block counts of all smaller classes.
  function automatic logic [31:0] base_of(input logic [CLASS_W-1:0] c);
    return 32'(LINK_DEPTH) - (32'(LINK_DEPTH) >> c);
  endfunction

  logic                mode_r;
  logic [REQ_W-1:0]    req_r;
  logic [BADDR_W-1:0]  baddr_r;
  logic [CNT_W-1:0]    carve_r    [NUM_CLASSES];
  logic [LIDX_W-1:0]   head_r     [NUM_CLASSES];
  logic                nonempty_r [NUM_CLASSES];
  logic [CIDX_W-1:0]   pcls_r;
  logic                strobe_r;
  logic [STATUS_W-1:0] status_r;
  logic [CLASS_W-1:0]  class_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [BYTES_W-1:0]  bytes_r;

  logic [CLASS_W-1:0]  acls;
  logic                ahit;
  logic                fext;
  logic [CLASS_W-1:0]  fcls;
  logic [31:0]         fslot;
  logic [CLASS_W-1:0]  cls;
  logic [CIDX_W-1:0]   ci;
  logic [LIDX_W-1:0]   head;
  logic                ne;
  logic [CNT_W-1:0]    carve;
  logic                pop;
  logic                push;
  logic                carve_inc;
  scpa_status_t        status_nxt;
  logic [31:0]         slot_sel;
  logic [31:0]         addr_full;
  logic                show_blk;

  logic                ram_we;
  logic [LIDX_W-1:0]   ram_waddr;
  logic [LIDX_W:0]     ram_wdata;
  logic                ram_re;
  logic [LIDX_W:0]     ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      req_r   <= in_request_bytes;
      baddr_r <= in_block_address;
    end
  end

  // Smallest class whose block size covers the request.
  always_comb begin
    acls = '0;
    ahit = 1'b0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (32'(req_r) <= (32'(MIN_BLOCK_BYTES) << k)) begin
        acls = CLASS_W'(k);
        ahit = 1'b1;
      end
    end
  end

  // Free address decode: region gives the class, offset over block size the slot.
  always_comb begin
    fcls  = CLASS_W'(32'(baddr_r) >> RG_LOG);
    fslot = (32'(baddr_r) & (32'(REGION_BYTES) - 32'd1)) >> (MB_LOG + 32'(fcls));
    fext  = (32'(baddr_r) >= POOL_END) || (fslot >= slots_of(fcls));
  end

  assign cls   = mode_r ? fcls : acls;
  assign ci    = cls[CIDX_W-1:0];
  assign head  = head_r[ci];
  assign ne    = nonempty_r[ci];
  assign carve = carve_r[ci];

  always_comb begin
    status_nxt = ST_ZERO;
    pop        = 1'b0;
    push       = 1'b0;
    carve_inc  = 1'b0;
    slot_sel   = '0;
    if (!mode_r) begin
      priority if (req_r == '0) begin
        status_nxt = ST_ZERO;
      end else if (!ahit) begin
        status_nxt = ST_TOO_LARGE;
      end else if (ne) begin
        status_nxt = ST_GRANTED;
        pop        = 1'b1;
        slot_sel   = 32'(head) - base_of(cls);
      end else if (32'(carve) < slots_of(cls)) begin
        status_nxt = ST_GRANTED;
        carve_inc  = 1'b1;
        slot_sel   = 32'(carve);
      end else begin
        status_nxt = ST_EXHAUSTED;
      end
    end else begin
      if (fext) begin
        status_nxt = ST_EXTERNAL;
      end else begin
        status_nxt = ST_FREED;
        push       = 1'b1;
        slot_sel   = fslot;
      end
    end
  end

  assign show_blk  = (status_nxt == ST_GRANTED) || (status_nxt == ST_FREED);
  assign addr_full = (32'(cls) << RG_LOG) + (slot_sel << (MB_LOG + 32'(cls)));
  assign stat.pop  = cmd.exec && pop;

  // A push stores the old head and its valid flag at the freed block's link entry.
  assign ram_we    = cmd.exec && push;
  assign ram_waddr = LIDX_W'(base_of(fcls) + fslot);
  assign ram_wdata = {ne, head};
  assign ram_re    = cmd.exec && pop;

  scpa_ram #(
    .WIDTH (LIDX_W + 1),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        carve_r[k]    <= '0;
        head_r[k]     <= '0;
        nonempty_r[k] <= 1'b0;
      end
    end else begin
      strobe_r <= cmd.exec;
      if (cmd.exec && carve_inc) begin
        carve_r[ci] <= carve + CNT_W'(1);
      end
      if (cmd.exec && push) begin
        head_r[ci]     <= ram_waddr;
        nonempty_r[ci] <= 1'b1;
      end
      if (cmd.finish) begin
        head_r[pcls_r]     <= ram_rdata[LIDX_W-1:0];
        nonempty_r[pcls_r] <= ram_rdata[LIDX_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pcls_r   <= ci;
      status_r <= status_nxt;
      class_r  <= (show_blk || (status_nxt == ST_EXHAUSTED)) ? cls : '0;
      slot_r   <= show_blk ? SLOT_W'(slot_sel) : '0;
      addr_r   <= show_blk ? ADDR_W'(addr_full) : '0;
      bytes_r  <= (status_nxt == ST_GRANTED) ?
                  BYTES_W'(32'(MIN_BLOCK_BYTES) << cls) : '0;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_block_class = class_r;
  assign out_slot        = slot_r;
  assign out_address     = addr_r;
  assign out_block_bytes = bytes_r;

endmodule

`default_nettype wire

@@ design/size_class_pool_allocator.sv @@
// Top level of the size-class pool allocator.
// Depends on scpa_pkg, scpa_ctrl, scpa_dpath and scpa_ram.
`default_nettype none

// Usage
// A request is a transfer on the command port: it is taken at a rising edge
// at which start is high and busy is low. in_mode selects allocate (0) or
// free (1); in_request_bytes is the size for an allocate and in_block_address
// the byte address for a free. Every request gives exactly one result, shown
// on the out_ ports for a single cycle while out_strobe is high. The receiver
// cannot hold a result off, so it must take it in that cycle.
// The transfer edge is followed by the execute cycle, and the result is
// shown in the cycle after that, to be taken at the rising edge at its end.
// Busy is high in the execute cycle after each transfer, so no request is
// taken while the last one executes; the next can be taken while its result
// is shown. A pop from a free list reads the link RAM at the list head in the
// execute cycle; the next head is written back in the following cycle, during
// which a new request can already be taken.
// Reset (synchronous, rst_n low) empties every free list, zeroes the carve
// counters and drops any pending result. The link RAM is not cleared: an
// entry is only read after a free has written it.
module size_class_pool_allocator #(
  parameter int NUM_CLASSES     = scpa_pkg::NUM_CLASSES_DEF,
  parameter int REGION_BYTES    = scpa_pkg::REGION_BYTES_DEF,
  parameter int MIN_BLOCK_BYTES = scpa_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [scpa_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [scpa_pkg::BADDR_W-1:0]  in_block_address,
  output logic                          out_strobe,
  output logic [scpa_pkg::STATUS_W-1:0] out_status,
  output logic [scpa_pkg::CLASS_W-1:0]  out_block_class,
  output logic [scpa_pkg::SLOT_W-1:0]   out_slot,
  output logic [scpa_pkg::ADDR_W-1:0]   out_address,
  output logic [scpa_pkg::BYTES_W-1:0]  out_block_bytes
);
  import scpa_pkg::*;

  scpa_cmd_t  cmd;
  scpa_stat_t stat;

  // The controller only sequences; all request state lives in the datapath.
  scpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  scpa_dpath #(
    .NUM_CLASSES     (NUM_CLASSES),
    .REGION_BYTES    (REGION_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_request_bytes (in_request_bytes),
    .in_block_address (in_block_address),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_block_class  (out_block_class),
    .out_slot         (out_slot),
    .out_address      (out_address),
    .out_block_bytes  (out_block_bytes)
  );

endmodule

`default_nettype wire

@@ design/scpa_checker.sv @@
// Port-level checks of the size-class pool allocator, bound to its top level.
// Depends on scpa_pkg and size_class_pool_allocator.
`default_nettype none

module scpa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [scpa_pkg::STATUS_W-1:0] out_status,
  input logic [scpa_pkg::BYTES_W-1:0]  out_block_bytes
);
  import scpa_pkg::*;

  // Every transfer is followed by its execute cycle and then by its result.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after a transfer");

  // Busy is raised in the cycle after a transfer and then falls again.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // A result only follows an execute cycle.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a preceding request");

  // Only a grant reports a block size.
  a_bytes_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_GRANTED)) |-> (out_block_bytes == '0))
    else $error("block size reported without a grant");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);

`default_nettype wire

@@ verif/size_class_pool_allocator_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the size-class pool allocator: directed and random
// allocate and free requests, predicted and compared field by field.
// Depends on scpa_pkg and size_class_pool_allocator.

module size_class_pool_allocator_test;
  import scpa_pkg::*;

  // Geometry of the pool, taken from the package defaults the block uses.
  localparam int N_CLS      = NUM_CLASSES_DEF;
  localparam int REGION     = REGION_BYTES_DEF;
  localparam int MIN_BLOCK  = MIN_BLOCK_BYTES_DEF;
  localparam int POOL_END   = N_CLS * REGION;
  localparam int LINK_SLOTS = 4096;

  // Request codes on in_mode.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // A run that goes this many cycles without any transfer has hung.
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    scpa_status_t         status;
    logic [CLASS_W-1:0]   blk_class;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_W-1:0]    address;
    logic [BYTES_W-1:0]   block_bytes;
  } outcome_t;

  // The ledger keeps its own copy of the allocator state: carve counters,
  // free-list heads and the per-block links. Every accepted request is
  // resolved against it at once, and the outcome waits in a queue until the
  // block shows its result.
  class pool_ledger;
    int unsigned        carve_count [N_CLS];
    logic [11:0]        list_head [N_CLS];
    bit                 list_nonempty [N_CLS];
    logic [11:0]        next_link [LINK_SLOTS];
    bit                 link_valid [LINK_SLOTS];
    outcome_t           expected_outcomes [$];
    logic [ADDR_W-1:0]  live_blocks [$];
    scpa_status_t       last_status;
    int                 failures;

    function new();
      foreach (carve_count[c]) begin
        carve_count[c] = 0;
        list_head[c] = '0;
        list_nonempty[c] = 1'b0;
      end
      foreach (next_link[i]) begin
        next_link[i] = '0;
        link_valid[i] = 1'b0;
      end
      failures = 0;
      last_status = ST_GRANTED;
    endfunction

    function int unsigned block_size(int c);
      return MIN_BLOCK << c;
    endfunction

    function int unsigned slots_in(int c);
      return REGION / block_size(c);
    endfunction

    // Links are numbered across classes: each class starts where the
    // previous one's blocks end.
    function int unsigned link_base(int c);
      int unsigned b;
      b = 0;
      for (int k = 0; k < c; k++) b += slots_in(k);
      return b;
    endfunction

    function outcome_t resolve_request(logic mode, logic [REQ_W-1:0] bytes,
                                       logic [BADDR_W-1:0] baddr);
      outcome_t    o;
      int          c;
      int unsigned slot;
      int unsigned idx;
      bit          granted;
      o = '0;
      granted = 1'b0;
      slot = 0;
      c = 0;
      if (mode == MODE_ALLOC) begin
        if (bytes == 0) begin
          o.status = ST_ZERO;
        end else begin
          while (c < N_CLS && bytes > block_size(c)) c++;
          if (c == N_CLS) begin
            o.status = ST_TOO_LARGE;
          end else if (list_nonempty[c]) begin
            idx = list_head[c];
            slot = idx - link_base(c);
            list_head[c] = next_link[idx];
            list_nonempty[c] = link_valid[idx];
            granted = 1'b1;
          end else if (carve_count[c] < slots_in(c)) begin
            slot = carve_count[c];
            carve_count[c]++;
            granted = 1'b1;
          end else begin
            o.status = ST_EXHAUSTED;
            o.blk_class = CLASS_W'(c);
          end
        end
        if (granted) begin
          o.status = ST_GRANTED;
          o.blk_class = CLASS_W'(c);
          o.slot = SLOT_W'(slot);
          o.address = ADDR_W'(c * REGION + slot * block_size(c));
          o.block_bytes = BYTES_W'(block_size(c));
        end
      end else if (baddr >= POOL_END) begin
        o.status = ST_EXTERNAL;
      end else begin
        c = baddr / REGION;
        slot = (baddr % REGION) / block_size(c);
        if (slot >= slots_in(c)) begin
          o.status = ST_EXTERNAL;
        end else begin
          // A free rounds down to its block and pushes it on the list top.
          idx = link_base(c) + slot;
          next_link[idx] = list_head[c];
          link_valid[idx] = list_nonempty[c];
          list_head[c] = idx[11:0];
          list_nonempty[c] = 1'b1;
          o.status = ST_FREED;
          o.blk_class = CLASS_W'(c);
          o.slot = SLOT_W'(slot);
          o.address = ADDR_W'(c * REGION + slot * block_size(c));
        end
      end
      return o;
    endfunction

    function void note_request(logic mode, logic [REQ_W-1:0] bytes,
                               logic [BADDR_W-1:0] baddr);
      outcome_t o;
      o = resolve_request(mode, bytes, baddr);
      if (o.status == ST_GRANTED) live_blocks.push_back(o.address);
      last_status = o.status;
      expected_outcomes.push_back(o);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d address %0d",
                 $time, got.status, got.address);
        failures++;
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("block_class", want.blk_class, got.blk_class);
        compare_field("slot", want.slot, got.slot);
        compare_field("address", want.address, got.address);
        compare_field("block_bytes", want.block_bytes, got.block_bytes);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                in_mode = MODE_ALLOC;
  logic [REQ_W-1:0]    in_request_bytes = '0;
  logic [BADDR_W-1:0]  in_block_address = '0;
  logic                busy;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic [CLASS_W-1:0]  out_block_class;
  logic [SLOT_W-1:0]   out_slot;
  logic [ADDR_W-1:0]   out_address;
  logic [BYTES_W-1:0]  out_block_bytes;

  pool_ledger pool = new();
  int         requests_taken = 0;
  int         quiet_cycles = 0;

  size_class_pool_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_request_bytes (in_request_bytes),
    .in_block_address (in_block_address),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_block_class  (out_block_class),
    .out_slot         (out_slot),
    .out_address      (out_address),
    .out_block_bytes  (out_block_bytes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Everything is sampled at the rising edge, where the inputs have been
  // steady since the falling edge. A request transfer is noted with the
  // ledger straight away, so the driver can see its outcome at the next
  // falling edge. The watchdog counts edges with no transfer in either
  // direction; reaching its limit means the block has hung.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pool.note_request(in_mode, in_request_bytes, in_block_address);
      requests_taken++;
    end
    if (rst_n && out_strobe) begin
      pool.check_result('{scpa_status_t'(out_status), out_block_class, out_slot,
                          out_address, out_block_bytes});
    end
    if (rst_n && ((start && !busy) || out_strobe)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one request from a falling edge and hold it until the block
  // takes it. On return we sit at the falling edge after the transfer, with
  // start still high so that a following request can go straight in.
  task automatic send_request(input logic mode, input logic [REQ_W-1:0] bytes,
                              input logic [BADDR_W-1:0] baddr);
    int seen;
    seen = requests_taken;
    start <= 1'b1;
    in_mode <= mode;
    in_request_bytes <= bytes;
    in_block_address <= baddr;
    @(negedge clk);
    while (requests_taken == seen) @(negedge clk);
  endtask

  // Leave the request port idle for a random stretch; the chance of each
  // further idle cycle is the given percentage. Gap lengths vary, so the
  // gaps fall on both the execute and the result cycle of the block.
  task automatic idle_sender(input int pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the request port until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pool.expected_outcomes.size() != 0) @(negedge clk);
  endtask

  // One random request. Most are well formed: allocations spread across
  // all classes and frees of blocks that were granted earlier, sometimes
  // pointing into the middle of the block. The remainder is noise: zero,
  // oversized and random-sized allocations, frees of arbitrary pool addresses
  // (which may free a block twice) and frees outside the pool.
  task automatic random_request();
    int                  pick;
    int                  k;
    int                  i;
    logic [BADDR_W-1:0]  a;
    pick = $urandom_range(0, 99);
    if (pick < 85 && pick >= 58 && pool.live_blocks.size() == 0) pick = 0;
    if (pick < 50) begin
      k = $urandom_range(0, N_CLS - 1);
      send_request(MODE_ALLOC,
                   REQ_W'($urandom_range(k == 0 ? 1 : (MIN_BLOCK << k) / 2 + 1,
                                         MIN_BLOCK << k)),
                   BADDR_W'($urandom));
    end else if (pick < 54) begin
      send_request(MODE_ALLOC, $urandom_range(0, 1) ? REQ_W'(0)
                   : REQ_W'($urandom_range(1025, 65535)), BADDR_W'($urandom));
    end else if (pick < 58) begin
      send_request(MODE_ALLOC, REQ_W'($urandom), BADDR_W'($urandom));
    end else if (pick < 85) begin
      i = $urandom_range(0, pool.live_blocks.size() - 1);
      a = pool.live_blocks[i];
      pool.live_blocks.delete(i);
      if ($urandom_range(0, 99) < 30)
        a = a + BADDR_W'($urandom_range(0, pool.block_size(a / REGION) - 1));
      send_request(MODE_FREE, REQ_W'($urandom), a);
    end else if (pick < 95) begin
      send_request(MODE_FREE, REQ_W'($urandom), BADDR_W'($urandom_range(0, POOL_END - 1)));
    end else begin
      send_request(MODE_FREE, REQ_W'($urandom),
                   BADDR_W'($urandom_range(POOL_END, (1 << BADDR_W) - 1)));
    end
  endtask

  // Sender idle percentage for each phase: none, heavy, none again (the
  // receiver has no way to stall, so that phase runs at full rate) and light.
  int idle_pct [4] = '{0, 60, 0, 11};

  initial begin
    int exhausted_seen;
    int burst;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: field extremes, both request kinds, every status code but
    // exhaustion, misaligned frees, a free of a block never handed out, and a
    // double free that makes the class hand the same block out twice.
    send_request(MODE_ALLOC, 16'd0, '0);
    send_request(MODE_ALLOC, 16'hFFFF, '0);
    send_request(MODE_ALLOC, 16'd1025, '0);
    send_request(MODE_ALLOC, 16'd1, '0);
    send_request(MODE_ALLOC, 16'd32, '0);
    send_request(MODE_ALLOC, 16'd33, '0);
    send_request(MODE_ALLOC, 16'd512, '0);
    send_request(MODE_ALLOC, 16'd513, '0);
    send_request(MODE_ALLOC, 16'd1024, '0);
    send_request(MODE_FREE, 16'd0, 19'h7FFFF);
    send_request(MODE_FREE, 16'd0, BADDR_W'(POOL_END));
    send_request(MODE_FREE, 16'd0, 19'd0);
    send_request(MODE_FREE, 16'd0, BADDR_W'(POOL_END - 1));
    send_request(MODE_ALLOC, 16'd1024, '0);
    send_request(MODE_ALLOC, 16'd700, '0);
    send_request(MODE_ALLOC, 16'd20, '0);
    send_request(MODE_FREE, 16'd0, BADDR_W'(REGION + 37));
    send_request(MODE_FREE, 16'd0, BADDR_W'(REGION + 37));
    send_request(MODE_ALLOC, 16'd64, '0);
    send_request(MODE_ALLOC, 16'd64, '0);
    send_request(MODE_FREE, 16'hFFFF, 19'd0);
    send_request(MODE_ALLOC, 16'd256, 19'h7FFFF);

    // Let every result come home before going on.
    drain_results();

    // Run the largest class dry: it is carved out completely and must then
    // report exhaustion, naming the class.
    exhausted_seen = 0;
    burst = 0;
    while (exhausted_seen < 3 && burst < 150) begin
      send_request(MODE_ALLOC, REQ_W'($urandom_range(513, 1024)), BADDR_W'($urandom));
      if (pool.last_status == ST_EXHAUSTED) exhausted_seen++;
      burst++;
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < 140; n++) begin
        idle_sender(idle_pct[p]);
        random_request();
      end
      drain_results();
    end

    repeat (10) @(negedge clk);
    if (pool.failures == 0 && pool.expected_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
